>>> hdl/fpbq_pkg.sv
// ----------------------------------------------------------------------------
// fpbq_pkg
// Widths, register indexes, reset values and the shift-and-saturate helper
// shared by the biquad low-pass filter and its channel interfaces.
// ----------------------------------------------------------------------------
package fpbq_pkg;

  localparam int CH_W             = 2;
  localparam int SAMPLE_W         = 8;
  localparam int DATA_W           = 16;
  localparam int ACC_W            = 32;
  localparam int FRAC_BITS        = 14;
  localparam int DIGIT_W          = 4;
  localparam int NUM_DIGITS       = DATA_W / DIGIT_W;
  localparam int DCNT_W           = $clog2(NUM_DIGITS);
  localparam int NUM_REGS         = 5;
  localparam int REG_IDX_W        = 3;
  localparam int NUM_CHANNELS_DEF = 3;

  typedef logic [REG_IDX_W-1:0]    reg_idx_t;
  typedef logic signed [DATA_W-1:0] coef_t;

  localparam reg_idx_t REG_A1 = 3'd0;
  localparam reg_idx_t REG_A2 = 3'd1;
  localparam reg_idx_t REG_B0 = 3'd2;
  localparam reg_idx_t REG_B1 = 3'd3;
  localparam reg_idx_t REG_B2 = 3'd4;

  localparam coef_t COEF_RESET [NUM_REGS] = '{
    coef_t'(-25575), coef_t'(10508), coef_t'(329), coef_t'(658), coef_t'(329)
  };

  // Products in the order the sequencer computes them.
  typedef logic [2:0] op_t;
  localparam op_t OP_A1 = 3'd0;
  localparam op_t OP_A2 = 3'd1;
  localparam op_t OP_B0 = 3'd2;
  localparam op_t OP_B1 = 3'd3;
  localparam op_t OP_B2 = 3'd4;

  // Arithmetic right shift by FRAC_BITS, then clamp to the 16-bit signed range.
  function automatic logic signed [DATA_W-1:0] shift_sat(input logic [ACC_W-1:0] w);
    logic [ACC_W-FRAC_BITS-1:0] s;
    logic [DATA_W-1:0]          res;
    s = w[ACC_W-1:FRAC_BITS];
    if ((s[ACC_W-FRAC_BITS-1:DATA_W-1] == '0) || (s[ACC_W-FRAC_BITS-1:DATA_W-1] == '1)) begin
      res = s[DATA_W-1:0];
    end else if (s[ACC_W-FRAC_BITS-1]) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

>>> hdl/fpbq_if.sv
// ----------------------------------------------------------------------------
// fpbq_in_if / fpbq_out_if
// Valid/ready channels carrying raw samples in and filtered values out.
// ----------------------------------------------------------------------------
interface fpbq_in_if;
  logic                          valid;
  logic                          ready;
  logic [fpbq_pkg::CH_W-1:0]     channel;
  logic [fpbq_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface fpbq_out_if;
  logic                               valid;
  logic                               ready;
  logic [fpbq_pkg::CH_W-1:0]          out_channel;
  logic signed [fpbq_pkg::DATA_W-1:0] filtered;

  modport source (output valid, output out_channel, output filtered, input ready);
  modport sink   (input valid, input out_channel, input filtered, output ready);
endinterface

>>> hdl/fixed_point_biquad_lowpass.sv
// ----------------------------------------------------------------------------
// fixed_point_biquad_lowpass
// Multi-channel direct form II second-order low-pass filter, Q14 coefficients.
// ----------------------------------------------------------------------------
// A sample for a valid channel is accepted, then the five coefficient
// products run one after another through a single 4-bit digit-serial
// multiplier, with a step between the feedback and feed-forward products
// that saturates the new delay value; the result then goes to the output
// register once it is free. A sample for a channel at or above NUM_CHANNELS
// skips the products, returns zero and leaves the delay lines alone.
// The output register lets a new sample be accepted while the previous result
// waits to be taken. Coefficients may only be rewritten while the filter idles.
module fixed_point_biquad_lowpass #(
  parameter int NUM_CHANNELS = fpbq_pkg::NUM_CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  fpbq_in_if.sink                          in_chan,
  fpbq_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [fpbq_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [fpbq_pkg::DATA_W-1:0]      cfg_data
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SEL_W = (IDX_W > fpbq_pkg::CH_W) ? IDX_W : fpbq_pkg::CH_W;
  localparam int ACC_W = fpbq_pkg::ACC_W;
  localparam int DATA_W = fpbq_pkg::DATA_W;
  localparam int DIGIT_W = fpbq_pkg::DIGIT_W;
  localparam int DCNT_W = fpbq_pkg::DCNT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAC  = 4'b0010,
    S_MID  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                    state_r, state_nxt;
  fpbq_pkg::coef_t           coef_r [fpbq_pkg::NUM_REGS];
  logic signed [DATA_W-1:0]  dly1_r [NUM_CHANNELS];
  logic signed [DATA_W-1:0]  dly2_r [NUM_CHANNELS];

  logic [fpbq_pkg::CH_W-1:0] ch_r;
  logic [IDX_W-1:0]          ch_idx_r;
  logic                      ch_ok_r;
  logic signed [DATA_W-1:0]  d1_r, d2_r, d0_r;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic signed [ACC_W-1:0]   md_r;
  logic [DATA_W-1:0]         csh_r;
  fpbq_pkg::op_t             op_r;
  logic [DCNT_W-1:0]         dcnt_r;

  logic                      out_valid_r;
  logic [fpbq_pkg::CH_W-1:0] out_ch_r;
  logic signed [DATA_W-1:0]  out_y_r;

  logic [SEL_W-1:0]          in_sel;
  logic [IDX_W-1:0]          in_idx;
  logic                      in_ok;
  logic                      in_fire;
  logic                      out_free;
  logic signed [DATA_W-1:0]  rd_d1, rd_d2;
  logic signed [DATA_W-1:0]  d0_sat;
  logic                      dig_top;
  logic signed [DIGIT_W:0]   dval;
  logic [ACC_W-1:0]          term;
  logic                      sub_op;

  assign in_sel  = SEL_W'(in_chan.channel);
  assign in_idx  = in_sel[IDX_W-1:0];
  assign in_ok   = (int'(in_sel) < NUM_CHANNELS);
  assign in_fire = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_channel = out_ch_r;
  assign out_chan.filtered    = out_y_r;

  assign rd_d1  = in_ok ? dly1_r[in_idx] : '0;
  assign rd_d2  = in_ok ? dly2_r[in_idx] : '0;
  assign d0_sat = fpbq_pkg::shift_sat(acc_r);

  // One coefficient digit per cycle; the top digit carries the sign.
  assign dig_top = (dcnt_r == DCNT_W'(fpbq_pkg::NUM_DIGITS - 1));
  assign dval    = dig_top ? {csh_r[DIGIT_W-1], csh_r[DIGIT_W-1:0]}
                           : {1'b0, csh_r[DIGIT_W-1:0]};
  assign term    = ACC_W'(md_r * dval);
  assign sub_op  = (op_r == fpbq_pkg::OP_A1) || (op_r == fpbq_pkg::OP_A2);
  assign acc_nxt = sub_op ? (acc_r - term) : (acc_r + term);

  function automatic logic signed [ACC_W-1:0] sext(input logic signed [DATA_W-1:0] v);
    return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = in_ok ? S_MAC : S_DONE;
        end
      end
      S_MAC: begin
        if (dig_top && (op_r == fpbq_pkg::OP_A2)) begin
          state_nxt = S_MID;
        end else if (dig_top && (op_r == fpbq_pkg::OP_B2)) begin
          state_nxt = S_DONE;
        end
      end
      S_MID: begin
        state_nxt = S_MAC;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < fpbq_pkg::NUM_REGS; i++) begin
        coef_r[i] <= fpbq_pkg::COEF_RESET[i];
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        dly1_r[i] <= '0;
        dly2_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we && (cfg_index < fpbq_pkg::REG_IDX_W'(fpbq_pkg::NUM_REGS))) begin
        coef_r[cfg_index] <= cfg_data;
      end

      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.valid && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            ch_r     <= in_chan.channel;
            ch_idx_r <= in_idx;
            ch_ok_r  <= in_ok;
            d1_r     <= rd_d1;
            d2_r     <= rd_d2;
            acc_r    <= ACC_W'(in_chan.sample) << fpbq_pkg::FRAC_BITS;
            md_r     <= sext(rd_d1);
            csh_r    <= coef_r[fpbq_pkg::REG_A1];
            op_r     <= fpbq_pkg::OP_A1;
            dcnt_r   <= '0;
          end
        end
        S_MAC: begin
          acc_r  <= acc_nxt;
          dcnt_r <= dig_top ? '0 : dcnt_r + 1'b1;
          if (dig_top) begin
            case (op_r)
              fpbq_pkg::OP_A1: begin
                op_r  <= fpbq_pkg::OP_A2;
                md_r  <= sext(d2_r);
                csh_r <= coef_r[fpbq_pkg::REG_A2];
              end
              fpbq_pkg::OP_B0: begin
                op_r  <= fpbq_pkg::OP_B1;
                md_r  <= sext(d1_r);
                csh_r <= coef_r[fpbq_pkg::REG_B1];
              end
              fpbq_pkg::OP_B1: begin
                op_r  <= fpbq_pkg::OP_B2;
                md_r  <= sext(d2_r);
                csh_r <= coef_r[fpbq_pkg::REG_B2];
              end
              default: begin
                op_r <= op_r;
              end
            endcase
          end else begin
            md_r  <= md_r <<< DIGIT_W;
            csh_r <= csh_r >> DIGIT_W;
          end
        end
        S_MID: begin
          d0_r   <= d0_sat;
          acc_r  <= '0;
          md_r   <= sext(d0_sat);
          csh_r  <= coef_r[fpbq_pkg::REG_B0];
          op_r   <= fpbq_pkg::OP_B0;
          dcnt_r <= '0;
        end
        S_DONE: begin
          if (out_free) begin
            out_ch_r    <= ch_r;
            out_y_r     <= ch_ok_r ? fpbq_pkg::shift_sat(acc_r) : '0;
            if (ch_ok_r) begin
              dly2_r[ch_idx_r] <= d1_r;
              dly1_r[ch_idx_r] <= d0_r;
            end
          end
        end
        default: begin
          op_r <= op_r;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("filter stayed idle after accepting a sample");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared without finishing a sample");

  a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (op_r <= fpbq_pkg::OP_B2))
    else $error("product sequencer ran past the last coefficient");

  a_bad_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (int'(out_ch_r) >= NUM_CHANNELS)) |-> (out_y_r == '0))
    else $error("nonzero result for an unused channel");
`endif

endmodule

>>> verif/tb_fixed_point_biquad_lowpass.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_point_biquad_lowpass
// Self-checking bench for the multi-channel biquad low-pass filter. Samples
// are sent over the input channel with random gaps, and results are taken
// with random stalls. A local Q14 filter model keeps its own coefficients
// and per-channel delay lines and predicts every filtered value, which is
// compared field by field with what the filter returns. Coefficients are
// rewritten between phases, reaching the extremes and an unused register
// index.
// ----------------------------------------------------------------------------
module tb_fixed_point_biquad_lowpass;

  localparam int CH_W      = fpbq_pkg::CH_W;
  localparam int SAMPLE_W  = fpbq_pkg::SAMPLE_W;
  localparam int DATA_W    = fpbq_pkg::DATA_W;
  localparam int ACC_W     = fpbq_pkg::ACC_W;
  localparam int FRAC_BITS = fpbq_pkg::FRAC_BITS;
  localparam int REG_IDX_W = fpbq_pkg::REG_IDX_W;
  localparam int NUM_REGS  = fpbq_pkg::NUM_REGS;

  typedef fpbq_pkg::coef_t    coef_t;
  typedef fpbq_pkg::reg_idx_t reg_idx_t;

  localparam int NUM_CH        = 3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int MAX_REPORTS   = 100;
  localparam int MAX_WAIT      = 6;

  localparam coef_t A1_AT_RESET = -16'sd25575;
  localparam coef_t A2_AT_RESET = 16'sd10508;
  localparam coef_t B0_AT_RESET = 16'sd329;
  localparam coef_t B1_AT_RESET = 16'sd658;
  localparam coef_t B2_AT_RESET = 16'sd329;

  localparam coef_t COEF_MIN = 16'sh8000;
  localparam coef_t COEF_MAX = 16'sh7fff;

  typedef struct packed {
    logic [CH_W-1:0]          ch;
    logic signed [DATA_W-1:0] value;
  } filtered_t;

  typedef enum {COEF_AT_RESET, COEF_ANY, COEF_EDGES, COEF_LOWPASS} coef_mix_t;
  typedef enum {WAVE_NOISE, WAVE_STEP, WAVE_SQUARE, WAVE_RAMP} wave_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  fpbq_in_if  sample_if ();
  fpbq_out_if filtered_if ();

  fixed_point_biquad_lowpass #(
    .NUM_CHANNELS(NUM_CH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (sample_if),
    .out_chan (filtered_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Filter model state.
  coef_t                    coef_shadow [NUM_REGS];
  logic signed [DATA_W-1:0] delay_first [NUM_CH];
  logic signed [DATA_W-1:0] delay_second [NUM_CH];
  filtered_t                pending_q [$];

  int error_count   = 0;
  int cycle_count   = 0;
  int in_gap_max    = MAX_WAIT;
  int out_stall_max = MAX_WAIT;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("cycle %0d: %s", cycle_count, msg);
    end
  endtask

  function automatic void reset_filter_model();
    coef_shadow[fpbq_pkg::REG_A1] = A1_AT_RESET;
    coef_shadow[fpbq_pkg::REG_A2] = A2_AT_RESET;
    coef_shadow[fpbq_pkg::REG_B0] = B0_AT_RESET;
    coef_shadow[fpbq_pkg::REG_B1] = B1_AT_RESET;
    coef_shadow[fpbq_pkg::REG_B2] = B2_AT_RESET;
    for (int c = 0; c < NUM_CH; c++) begin
      delay_first[c]  = '0;
      delay_second[c] = '0;
    end
  endfunction

  // Arithmetic shift out the Q14 fraction, then clamp to 16 bits signed.
  function automatic logic signed [DATA_W-1:0] q14_clamp(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] shifted;
    shifted = acc >>> FRAC_BITS;
    if (shifted > 32'sd32767) return COEF_MAX;
    if (shifted < -32'sd32768) return COEF_MIN;
    return shifted[DATA_W-1:0];
  endfunction

  function automatic filtered_t run_biquad(input logic [CH_W-1:0] ch,
                                           input logic [SAMPLE_W-1:0] smp);
    filtered_t                r;
    logic signed [ACC_W-1:0]  acc;
    logic signed [DATA_W-1:0] d0;
    logic signed [DATA_W-1:0] d1;
    logic signed [DATA_W-1:0] d2;
    r.ch    = ch;
    r.value = '0;
    // A channel with no delay line returns zero and touches nothing.
    if (ch >= NUM_CH) return r;
    d1  = delay_first[ch];
    d2  = delay_second[ch];
    acc = {{(ACC_W-SAMPLE_W-FRAC_BITS){1'b0}}, smp, {FRAC_BITS{1'b0}}};
    acc = acc - coef_shadow[fpbq_pkg::REG_A1] * d1;
    acc = acc - coef_shadow[fpbq_pkg::REG_A2] * d2;
    d0  = q14_clamp(acc);
    acc = coef_shadow[fpbq_pkg::REG_B0] * d0 + coef_shadow[fpbq_pkg::REG_B1] * d1
          + coef_shadow[fpbq_pkg::REG_B2] * d2;
    r.value = q14_clamp(acc);
    delay_second[ch] = d1;
    delay_first[ch]  = d0;
    return r;
  endfunction

  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    int gap;
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_if.valid   <= 1'b1;
    sample_if.channel <= ch;
    sample_if.sample  <= smp;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    pending_q.push_back(run_biquad(ch, smp));
  endtask

  // Drop valid and let every outstanding transaction come back.
  task automatic wait_idle();
    sample_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_coef(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx < NUM_REGS) coef_shadow[idx] = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_coefs(input coef_t a1, input coef_t a2, input coef_t b0,
                            input coef_t b1, input coef_t b2);
    write_coef(fpbq_pkg::REG_A1, a1);
    write_coef(fpbq_pkg::REG_A2, a2);
    write_coef(fpbq_pkg::REG_B0, b0);
    write_coef(fpbq_pkg::REG_B1, b1);
    write_coef(fpbq_pkg::REG_B2, b2);
  endtask

  function automatic coef_t edge_coef();
    case ($urandom_range(4, 0))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      2:       return '0;
      3:       return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  function automatic coef_t any_coef();
    return coef_t'($urandom_range(16'hffff, 0));
  endfunction

  task automatic apply_coef_mix(input coef_mix_t mix);
    case (mix)
      COEF_AT_RESET: load_coefs(A1_AT_RESET, A2_AT_RESET, B0_AT_RESET, B1_AT_RESET,
                                B2_AT_RESET);
      COEF_EDGES:    load_coefs(edge_coef(), edge_coef(), edge_coef(), edge_coef(),
                                edge_coef());
      COEF_LOWPASS:  load_coefs(coef_t'(-int'($urandom_range(32000, 12000))),
                                coef_t'($urandom_range(14000, 2000)),
                                coef_t'($urandom_range(2000, 0)),
                                coef_t'($urandom_range(4000, 0)),
                                coef_t'($urandom_range(2000, 0)));
      default:       load_coefs(any_coef(), any_coef(), any_coef(), any_coef(), any_coef());
    endcase
  endtask

  // Result side: random stalls, then compare each transaction with the oldest prediction.
  initial begin
    filtered_t got;
    filtered_t want;
    int        stall;
    filtered_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = $urandom_range(out_stall_max, 0);
      if (stall > 0) begin
        filtered_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      filtered_if.ready <= 1'b1;
      @(posedge clk);
      while (!filtered_if.valid) @(posedge clk);
      got.ch    = filtered_if.out_channel;
      got.value = filtered_if.filtered;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result: channel %0d value %0d",
                                  got.ch, got.value));
      end else begin
        want = pending_q.pop_front();
        if (got.ch !== want.ch) begin
          report_mismatch($sformatf("out_channel %0d, expected %0d", got.ch, want.ch));
        end
        if (got.value !== want.value) begin
          report_mismatch($sformatf("filtered %0d on channel %0d, expected %0d",
                                    got.value, want.ch, want.value));
        end
      end
    end
  end

  task automatic test_reset_coefficients();
    send_sample(2'd0, 8'd255);
    send_sample(2'd1, 8'd0);
    send_sample(2'd2, 8'd255);
    send_sample(2'd0, 8'd255);
    send_sample(2'd3, 8'd255);
    send_sample(2'd2, 8'haa);
    send_sample(2'd1, 8'h55);
    send_sample(2'd3, 8'd0);
    send_sample(2'd0, 8'd0);
    send_sample(2'd3, 8'haa);
    wait_idle();
  endtask

  // Writes past the register list must leave every coefficient alone.
  task automatic test_unused_index();
    for (int k = NUM_REGS; k < (1 << REG_IDX_W); k++) begin
      write_coef(reg_idx_t'(k), 16'h8000);
    end
    send_sample(2'd0, 8'd200);
    send_sample(2'd1, 8'd17);
    send_sample(2'd2, 8'd255);
    wait_idle();
  endtask

  task automatic test_coefficient_extremes();
    load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_sample(2'd0, 8'd255);
    send_sample(2'd0, 8'd255);
    send_sample(2'd1, 8'd1);
    wait_idle();
    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_sample(2'd0, 8'd255);
    send_sample(2'd2, 8'd128);
    send_sample(2'd3, 8'd255);
    wait_idle();
    load_coefs(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, '0);
    send_sample(2'd1, 8'd255);
    send_sample(2'd1, 8'd0);
    send_sample(2'd2, 8'd7);
    wait_idle();
    load_coefs('0, '0, '0, '0, '0);
    send_sample(2'd0, 8'd255);
    send_sample(2'd2, 8'd255);
    wait_idle();
  endtask

  // Stretches of shaped waveforms sent to random channels under changing pacing and coefficients.
  task automatic test_random_streams(input int phases, input int per_phase);
    coef_mix_t            mix;
    wave_t                wave;
    int                   sent;
    int                   stretch;
    logic [SAMPLE_W-1:0]  level;
    logic [SAMPLE_W-1:0]  smp;
    logic [SAMPLE_W-1:0]  step;
    logic [CH_W-1:0]      ch;
    for (int p = 0; p < phases; p++) begin
      if (p == 0) mix = COEF_AT_RESET;
      else if (p == 1) mix = COEF_EDGES;
      else mix = coef_mix_t'($urandom_range(3, 0));
      apply_coef_mix(mix);
      if ($urandom_range(2, 0) == 0) begin
        write_coef(reg_idx_t'($urandom_range((1 << REG_IDX_W) - 1, NUM_REGS)), any_coef());
      end
      sent = 0;
      while (sent < per_phase) begin
        stretch = $urandom_range(40, 10);
        case ($urandom_range(3, 0))
          0: begin in_gap_max = MAX_WAIT; out_stall_max = MAX_WAIT; end
          1: begin in_gap_max = 0;        out_stall_max = 0;        end
          2: begin in_gap_max = 0;        out_stall_max = MAX_WAIT; end
          default: begin in_gap_max = MAX_WAIT; out_stall_max = 0; end
        endcase
        wave  = wave_t'($urandom_range(3, 0));
        level = SAMPLE_W'($urandom_range(255, 0));
        step  = SAMPLE_W'($urandom_range(24, 1));
        for (int i = 0; i < stretch && sent < per_phase; i++) begin
          ch = ($urandom_range(9, 0) == 0) ? 2'd3 : CH_W'($urandom_range(NUM_CH - 1, 0));
          case (wave)
            WAVE_STEP:   smp = level;
            WAVE_SQUARE: smp = (i[2]) ? 8'd255 : 8'd0;
            WAVE_RAMP:   begin level = level + step; smp = level; end
            default:     smp = SAMPLE_W'($urandom_range(255, 0));
          endcase
          send_sample(ch, smp);
          sent++;
        end
      end
      wait_idle();
    end
    in_gap_max    = MAX_WAIT;
    out_stall_max = MAX_WAIT;
  endtask

  initial begin
    rst_n             <= 1'b0;
    sample_if.valid   <= 1'b0;
    sample_if.channel <= '0;
    sample_if.sample  <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= fpbq_pkg::REG_A1;
    cfg_data          <= '0;
    reset_filter_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_coefficients();
    test_unused_index();
    test_coefficient_extremes();
    test_random_streams(10, 123);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pending_q.size()));
    end
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
